FILE: src/cfl_pkg.sv
// Shared types and constants for the CTL fixpoint labeler.
`default_nettype none
package cfl_pkg;

    // Structure size and vector widths
    localparam int MAX_STATES = 64;
    localparam int VEC_W      = 64;
    localparam int IDX_W      = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CNT_W      = 7;
    localparam int PASS_W     = 7;
    localparam int FORM_W     = 4;
    localparam int SIDX_W     = 6;

    localparam logic [CNT_W-1:0] STATE_COUNT_RESET = CNT_W'(MAX_STATES);
    localparam logic [IDX_W-1:0] IDX_LAST          = IDX_W'(MAX_STATES - 1);

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Formula codes
    typedef enum logic [FORM_W-1:0] {
        F_EX    = 4'd0,
        F_AX    = 4'd1,
        F_EU    = 4'd2,
        F_AU    = 4'd3,
        F_EF    = 4'd4,
        F_AF    = 4'd5,
        F_EG    = 4'd6,
        F_AG    = 4'd7,
        F_NOT   = 4'd8,
        F_AND   = 4'd9,
        F_OR    = 4'd10,
        F_IMPLY = 4'd11
    } formula_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } seq_state_t;

    // Compute command handed from the top level to the sequencer
    typedef struct packed {
        logic                 start;
        logic [FORM_W-1:0]    formula;
        logic [VEC_W-1:0]     p;
        logic [VEC_W-1:0]     q;
        logic [VEC_W-1:0]     mask;
    } cfl_cmd_t;

endpackage
`default_nettype wire

FILE: src/ctl_fixpoint_labeler_top.sv
// Top level of the CTL fixpoint labeler: config, labels, row memory, sequencer.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  s_      | s_valid/s_ready + operation, index, row, p, q, | in
//          | formula                                        |
//  m_      | m_valid/m_ready + label_vector, passes_used    | out
//  cfg_    | cfg_wr_en + cfg_wr_data (state_count)          | in
//
// Loads can follow back to back. Boolean operators finish without a row
// sweep; EX and AX take one row sweep; fixpoint operators repeat the sweep
// pass by pass until the vector stops growing, each pass paced by the single
// row-memory read port (one row per cycle).
// Synchronous active-low reset; state_count resets to 64, labels to zero.
// The row memory has no reset: rows in use must be loaded before a compute.
// s_ready is high only while the sequencer is idle; a waiting result does
// not block new transfers until the next result is ready to be written.
`default_nettype none
module ctl_fixpoint_labeler_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [cfl_pkg::SIDX_W-1:0]    s_state_index,
    input  wire logic [cfl_pkg::VEC_W-1:0]     s_successor_row,
    input  wire logic                          s_p_bit,
    input  wire logic                          s_q_bit,
    input  wire logic [cfl_pkg::FORM_W-1:0]    s_formula,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [cfl_pkg::VEC_W-1:0]     m_label_vector,
    output logic      [cfl_pkg::PASS_W-1:0]    m_passes_used,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cfl_pkg::CNT_W-1:0]     cfg_wr_data
);
    import cfl_pkg::*;

    logic [CNT_W-1:0]  state_count_reg, state_count_next;
    logic [VEC_W-1:0]  p_labels_reg, p_labels_next;
    logic [VEC_W-1:0]  q_labels_reg, q_labels_next;

    logic              idle;
    logic              s_xfer;
    logic              load_en;
    logic [IDX_W-1:0]  load_idx;
    logic [CNT_W-1:0]  n_used;
    logic [VEC_W-1:0]  use_mask;
    logic [IDX_W-1:0]  rd_addr;
    logic [VEC_W-1:0]  rd_row;
    cfl_cmd_t          cmd;

    // Input handshake and load decode
    assign s_ready  = idle;
    assign s_xfer   = s_valid && s_ready;
    assign load_idx = s_state_index[IDX_W-1:0];
    assign load_en  = s_xfer && (s_operation == OP_LOAD)
                      && ({1'b0, s_state_index} < (SIDX_W + 1)'(MAX_STATES));

    // States in use, saturated, and its mask
    always_comb begin
        n_used = (state_count_reg > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES)
                                                        : state_count_reg;
        for (int i = 0; i < VEC_W; i++) begin
            use_mask[i] = (CNT_W'(i) < n_used);
        end
    end

    // Configuration and label updates
    always_comb begin
        state_count_next = state_count_reg;
        p_labels_next    = p_labels_reg;
        q_labels_next    = q_labels_reg;
        if (cfg_wr_en) begin
            state_count_next = cfg_wr_data;
        end
        if (load_en) begin
            p_labels_next[load_idx] = s_p_bit;
            q_labels_next[load_idx] = s_q_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg <= STATE_COUNT_RESET;
            p_labels_reg    <= '0;
            q_labels_reg    <= '0;
        end else begin
            state_count_reg <= state_count_next;
            p_labels_reg    <= p_labels_next;
            q_labels_reg    <= q_labels_next;
        end
    end

    // Compute command
    always_comb begin
        cmd.start   = s_xfer && (s_operation == OP_COMPUTE);
        cmd.formula = s_formula;
        cmd.p       = p_labels_reg & use_mask;
        cmd.q       = q_labels_reg & use_mask;
        cmd.mask    = use_mask;
    end

    cfl_row_mem u_row_mem (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (load_idx),
        .wr_data (s_successor_row),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    cfl_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .idle           (idle),
        .rd_addr        (rd_addr),
        .rd_row         (rd_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_label_vector (m_label_vector),
        .m_passes_used  (m_passes_used)
    );

endmodule
`default_nettype wire

FILE: src/cfl_row_mem.sv
// Successor matrix storage: one write port, one registered read port.
`default_nettype none
module cfl_row_mem (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [cfl_pkg::IDX_W-1:0]  wr_addr,
    input  wire logic [cfl_pkg::VEC_W-1:0]  wr_data,
    input  wire logic [cfl_pkg::IDX_W-1:0]  rd_addr,
    output logic      [cfl_pkg::VEC_W-1:0]  rd_data
);
    import cfl_pkg::*;

    logic [VEC_W-1:0] mem [MAX_STATES];
    logic [VEC_W-1:0] rd_data_reg;

    // Row write on load transfer
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered row read
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: src/cfl_seq.sv
// Sequencer with the shared row test unit, fixpoint registers and result register.
`default_nettype none
module cfl_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cfl_pkg::cfl_cmd_t           cmd,
    output logic                             idle,
    output logic      [cfl_pkg::IDX_W-1:0]   rd_addr,
    input  wire logic [cfl_pkg::VEC_W-1:0]   rd_row,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [cfl_pkg::VEC_W-1:0]   m_label_vector,
    output logic      [cfl_pkg::PASS_W-1:0]  m_passes_used
);
    import cfl_pkg::*;

    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               issue_reg, issue_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [VEC_W-1:0]   res_reg, res_next;
    logic [VEC_W-1:0]   step_reg, step_next;
    logic [VEC_W-1:0]   p_reg, p_next;
    logic [VEC_W-1:0]   mask_reg, mask_next;
    logic               univ_reg, univ_next;
    logic               iter_reg, iter_next;
    logic               inv_reg, inv_next;
    logic [PASS_W-1:0]  passes_reg, passes_next;
    logic [VEC_W-1:0]   result_reg, result_next;
    logic               m_valid_reg, m_valid_next;
    logic [VEC_W-1:0]   m_label_reg, m_label_next;
    logic [PASS_W-1:0]  m_passes_reg, m_passes_next;

    logic [VEC_W-1:0]   hit_vec;
    logic               row_bit;
    logic [VEC_W-1:0]   step_full;
    logic [VEC_W-1:0]   grown;

    // Shared row test: exists-successor-in-v or all-successors-in-v
    always_comb begin
        hit_vec   = rd_row & mask_reg & (univ_reg ? ~res_reg : res_reg);
        row_bit   = univ_reg ? (hit_vec == '0) : (hit_vec != '0);
        step_full = step_reg | (VEC_W'(row_bit) << rd_idx_reg);
        grown     = res_reg | (p_reg & step_full);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        res_reg      <= res_next;
        step_reg     <= step_next;
        p_reg        <= p_next;
        mask_reg     <= mask_next;
        univ_reg     <= univ_next;
        iter_reg     <= iter_next;
        inv_reg      <= inv_next;
        passes_reg   <= passes_next;
        result_reg   <= result_next;
        m_label_reg  <= m_label_next;
        m_passes_reg <= m_passes_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        res_next      = res_reg;
        step_next     = step_reg;
        p_next        = p_reg;
        mask_next     = mask_reg;
        univ_next     = univ_reg;
        iter_next     = iter_reg;
        inv_next      = inv_reg;
        passes_next   = passes_reg;
        result_next   = result_reg;
        m_valid_next  = m_valid_reg;
        m_label_next  = m_label_reg;
        m_passes_next = m_passes_reg;

        // Output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    mask_next   = cmd.mask;
                    passes_next = '0;
                    univ_next   = 1'b0;
                    iter_next   = 1'b0;
                    inv_next    = 1'b0;
                    p_next      = cmd.mask;
                    res_next    = cmd.p & cmd.mask;
                    idx_next    = '0;
                    step_next   = '0;
                    case (formula_t'(cmd.formula))
                        F_EX: begin
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_AX: begin
                            univ_next  = 1'b1;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_EU: begin
                            iter_next  = 1'b1;
                            p_next     = cmd.p & cmd.mask;
                            res_next   = cmd.q & cmd.mask;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_AU: begin
                            iter_next  = 1'b1;
                            univ_next  = 1'b1;
                            p_next     = cmd.p & cmd.mask;
                            res_next   = cmd.q & cmd.mask;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_EF: begin
                            iter_next  = 1'b1;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_AF: begin
                            iter_next  = 1'b1;
                            univ_next  = 1'b1;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_EG: begin
                            // EG p = not A[true U not p]
                            iter_next  = 1'b1;
                            univ_next  = 1'b1;
                            inv_next   = 1'b1;
                            res_next   = ~cmd.p & cmd.mask;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_AG: begin
                            // AG p = not E[true U not p]
                            iter_next  = 1'b1;
                            inv_next   = 1'b1;
                            res_next   = ~cmd.p & cmd.mask;
                            state_next = ST_SWEEP;
                            issue_next = 1'b1;
                        end
                        F_NOT: begin
                            result_next = ~cmd.p & cmd.mask;
                            state_next  = ST_DONE;
                        end
                        F_AND: begin
                            result_next = cmd.p & cmd.q & cmd.mask;
                            state_next  = ST_DONE;
                        end
                        F_OR: begin
                            result_next = (cmd.p | cmd.q) & cmd.mask;
                            state_next  = ST_DONE;
                        end
                        F_IMPLY: begin
                            result_next = (~cmd.p | cmd.q) & cmd.mask;
                            state_next  = ST_DONE;
                        end
                        default: begin
                            // unknown code: dropped, no result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SWEEP: begin
                // Issue row reads one per cycle
                if (issue_reg) begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = idx_reg;
                    if (idx_reg == IDX_LAST) begin
                        issue_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end

                // Collect one row test result per cycle
                if (rd_valid_reg) begin
                    step_next = step_full;
                    if (rd_idx_reg == IDX_LAST) begin
                        if (!iter_reg) begin
                            result_next = step_full & mask_reg;
                            state_next  = ST_DONE;
                        end else begin
                            passes_next = passes_reg + PASS_W'(1);
                            if (grown == res_reg) begin
                                result_next = (inv_reg ? ~res_reg : res_reg) & mask_reg;
                                state_next  = ST_DONE;
                            end else begin
                                // next pass from the grown vector
                                res_next   = grown;
                                step_next  = '0;
                                idx_next   = '0;
                                issue_next = 1'b1;
                            end
                        end
                    end
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_label_next  = result_reg;
                    m_passes_next = passes_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle           = (state_reg == ST_IDLE);
    assign rd_addr        = idx_reg;
    assign m_valid        = m_valid_reg;
    assign m_label_vector = m_label_reg;
    assign m_passes_used  = m_passes_reg;

    // Pass count bounded by one pass per state plus the settling pass
    a_passes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (passes_reg <= PASS_W'(MAX_STATES + 1)))
        else $error("fixpoint pass count out of range");

    // Result never has bits outside the states in use
    a_result_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> ((result_reg & ~mask_reg) == '0))
        else $error("result has bits beyond state count");

    // Non-iterating operators report zero passes
    a_no_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !iter_reg) |-> (passes_reg == '0))
        else $error("pass count set for non-fixpoint operator");

    // Fixpoint vector only grows within one computation
    a_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && $past(state_reg) == ST_SWEEP)
            |-> (($past(res_reg) & ~res_reg) == '0))
        else $error("fixpoint vector lost a state");

    // Row data returns only during a sweep
    a_rd_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_SWEEP))
        else $error("row data outside sweep");

endmodule
`default_nettype wire
